### sv/nus_pkg.sv
package nus_pkg;

  localparam int MAX_IN_WIDTH  = 64;
  localparam int MAX_IN_HEIGHT = 64;
  localparam int MAX_DEPTH     = 256;
  localparam int MAX_FACTOR    = 8;

  localparam int HREG_W = 7;
  localparam int WREG_W = 7;
  localparam int DREG_W = 9;
  localparam int FREG_W = 4;

  localparam int COL_W  = $clog2(MAX_IN_WIDTH);
  localparam int ROW_W  = $clog2(MAX_IN_HEIGHT);
  localparam int CH_W   = $clog2(MAX_DEPTH);
  localparam int FACT_W = $clog2(MAX_FACTOR);

  localparam int VAL_W   = 16;
  localparam int SUM_W   = 24;
  localparam int OIDX_W  = 9;
  localparam int OCH_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT = 3'd0,
    REG_IN_WIDTH  = 3'd1,
    REG_IN_DEPTH  = 3'd2,
    REG_FACTOR_H  = 3'd3,
    REG_FACTOR_W  = 3'd4,
    REG_DIRECTION = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [HREG_W-1:0] in_height;
    logic [WREG_W-1:0] in_width;
    logic [DREG_W-1:0] in_depth;
    logic [FREG_W-1:0] factor_h;
    logic [FREG_W-1:0] factor_w;
    logic              direction;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [ROW_W-1:0]  sr;
    logic [FACT_W-1:0] wr;
    logic [COL_W-1:0]  sc;
    logic [FACT_W-1:0] wc;
  } pos_t;

  function automatic logic [DREG_W-1:0] clamp_dim(input logic [DREG_W-1:0] v,
                                                  input logic [DREG_W-1:0] hi);
    logic [DREG_W-1:0] r;
    if (v == '0) begin
      r = DREG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### sv/nearest_upsample_and_window_sum.sv
// Channel  Dir  Request                   Handshake
// in_      in   sample_value              in_tvalid / in_tready
// out_     out  result, ch, row, col      out_tvalid / out_tready, tlast
// cfg_     in   register index and data   cfg_valid / cfg_ready
//
// Backward: one request per cycle unless a window sum waits on the output.
// Forward: one result per cycle while the output accepts, factor_h * factor_w
// results per request, from the single window stage feeding the result register.
// Partial sums sit in a 64-entry memory; a read bypass covers back-to-back use.
// Reset is synchronous; the result register decouples output stalls by one item.
module nearest_upsample_and_window_sum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] sample_value
  input  logic [nus_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [23:0] result_value, [31:24] out_channel, [40:32] out_row,
  // [49:41] out_col, [55:50] zero
  output logic [nus_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nus_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nus_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import nus_pkg::*;

  cfg_t cfg;
  pos_t pos;
  logic restart;
  logic in_acc;
  logic win_ready;
  logic signed [SUM_W-1:0] o_value;
  logic [OCH_W-1:0]        o_channel;
  logic [OIDX_W-1:0]       o_row;
  logic [OIDX_W-1:0]       o_col;

  assign cfg_ready = 1'b1;
  assign in_tready = win_ready;
  assign in_acc    = in_tvalid && win_ready;

  nus_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg),
    .restart (restart)
  );

  nus_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .restart (restart),
    .advance (in_acc),
    .pos     (pos)
  );

  nus_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_accept (in_acc),
    .in_value  (in_tdata[VAL_W-1:0]),
    .in_pos    (pos),
    .in_ready  (win_ready),
    .o_valid   (out_tvalid),
    .o_ready   (out_tready),
    .o_value   (o_value),
    .o_channel (o_channel),
    .o_row     (o_row),
    .o_col     (o_col),
    .o_last    (out_tlast)
  );

  assign out_tdata = {6'b0, o_col, o_row, o_channel, o_value};

endmodule

### sv/nus_cfg.sv
module nus_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [nus_pkg::CFG_IDX_W-1:0]    wr_idx,
  input  logic [nus_pkg::CFG_DATA_W-1:0]   wr_data,
  output nus_pkg::cfg_t                    cfg,
  output logic                             restart
);
  import nus_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic hit;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (wr_en) begin
      unique case (wr_idx)
        REG_IN_HEIGHT: begin
          cfg_nxt.in_height = HREG_W'(clamp_dim({2'b00, wr_data[HREG_W-1:0]},
                                                DREG_W'(MAX_IN_HEIGHT)));
          hit = 1'b1;
        end
        REG_IN_WIDTH: begin
          cfg_nxt.in_width = WREG_W'(clamp_dim({2'b00, wr_data[WREG_W-1:0]},
                                               DREG_W'(MAX_IN_WIDTH)));
          hit = 1'b1;
        end
        REG_IN_DEPTH: begin
          cfg_nxt.in_depth = clamp_dim(wr_data, DREG_W'(MAX_DEPTH));
          hit = 1'b1;
        end
        REG_FACTOR_H: begin
          cfg_nxt.factor_h = FREG_W'(clamp_dim({5'b0, wr_data[FREG_W-1:0]},
                                               DREG_W'(MAX_FACTOR)));
          hit = 1'b1;
        end
        REG_FACTOR_W: begin
          cfg_nxt.factor_w = FREG_W'(clamp_dim({5'b0, wr_data[FREG_W-1:0]},
                                               DREG_W'(MAX_FACTOR)));
          hit = 1'b1;
        end
        REG_DIRECTION: begin
          cfg_nxt.direction = wr_data[0];
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_height <= HREG_W'(1);
      cfg_r.in_width  <= WREG_W'(1);
      cfg_r.in_depth  <= DREG_W'(1);
      cfg_r.factor_h  <= FREG_W'(1);
      cfg_r.factor_w  <= FREG_W'(1);
      cfg_r.direction <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign restart = hit;

endmodule

### sv/nus_seq.sv
module nus_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  nus_pkg::cfg_t  cfg,
  input  logic           restart,
  input  logic           advance,
  output nus_pkg::pos_t  pos
);
  import nus_pkg::*;

  pos_t pos_r;
  pos_t pos_nxt;
  logic [FREG_W-1:0] fw_eff;
  logic [FREG_W-1:0] fh_eff;
  logic wc_wrap, sc_wrap, wr_wrap, sr_wrap, ch_wrap;

  always_comb begin
    fw_eff  = cfg.direction ? cfg.factor_w : FREG_W'(1);
    fh_eff  = cfg.direction ? cfg.factor_h : FREG_W'(1);
    wc_wrap = ({1'b0, pos_r.wc} == fw_eff - FREG_W'(1));
    sc_wrap = ({1'b0, pos_r.sc} == cfg.in_width - WREG_W'(1));
    wr_wrap = ({1'b0, pos_r.wr} == fh_eff - FREG_W'(1));
    sr_wrap = ({1'b0, pos_r.sr} == cfg.in_height - HREG_W'(1));
    ch_wrap = ({1'b0, pos_r.ch} == cfg.in_depth - DREG_W'(1));
    pos_nxt = pos_r;
    if (restart) begin
      pos_nxt = '0;
    end else if (advance) begin
      if (!wc_wrap) begin
        pos_nxt.wc = pos_r.wc + FACT_W'(1);
      end else begin
        pos_nxt.wc = '0;
        if (!sc_wrap) begin
          pos_nxt.sc = pos_r.sc + COL_W'(1);
        end else begin
          pos_nxt.sc = '0;
          if (!wr_wrap) begin
            pos_nxt.wr = pos_r.wr + FACT_W'(1);
          end else begin
            pos_nxt.wr = '0;
            if (!sr_wrap) begin
              pos_nxt.sr = pos_r.sr + ROW_W'(1);
            end else begin
              pos_nxt.sr = '0;
              pos_nxt.ch = ch_wrap ? '0 : pos_r.ch + CH_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

### sv/nus_win.sv
module nus_win (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nus_pkg::cfg_t                     cfg,
  input  logic                              in_accept,
  input  logic signed [nus_pkg::VAL_W-1:0]  in_value,
  input  nus_pkg::pos_t                     in_pos,
  output logic                              in_ready,
  output logic                              o_valid,
  input  logic                              o_ready,
  output logic signed [nus_pkg::SUM_W-1:0]  o_value,
  output logic [nus_pkg::OCH_W-1:0]         o_channel,
  output logic [nus_pkg::OIDX_W-1:0]        o_row,
  output logic [nus_pkg::OIDX_W-1:0]        o_col,
  output logic                              o_last
);
  import nus_pkg::*;

  logic [SUM_W-1:0] psum_mem [MAX_IN_WIDTH];

  logic                     s1_valid_r;
  logic signed [VAL_W-1:0]  s1_val_r;
  pos_t                     s1_pos_r;
  logic [SUM_W-1:0]         s1_rd_r;
  logic [FACT_W-1:0]        i_r;
  logic [FACT_W-1:0]        j_r;

  logic                     out_valid_r;
  logic [SUM_W-1:0]         out_value_r;
  logic [OCH_W-1:0]         out_ch_r;
  logic [OIDX_W-1:0]        out_row_r;
  logic [OIDX_W-1:0]        out_col_r;
  logic                     out_last_r;

  logic [SUM_W-1:0]         v_ext;
  logic [SUM_W-1:0]         sum;
  logic                     win_start, win_end, fwd_last, j_wrap;
  logic                     has_result, out_free, emit, s1_done, mem_wr;
  logic [SUM_W-1:0]         res_value;
  logic [OIDX_W-1:0]        res_row, res_col;
  logic [ROW_W+FREG_W-1:0]  row_prod;
  logic [COL_W+FREG_W-1:0]  col_prod;

  always_comb begin
    v_ext     = SUM_W'(s1_val_r);
    win_start = (s1_pos_r.wr == '0) && (s1_pos_r.wc == '0);
    win_end   = ({1'b0, s1_pos_r.wr} == cfg.factor_h - FREG_W'(1)) &&
                ({1'b0, s1_pos_r.wc} == cfg.factor_w - FREG_W'(1));
    sum       = win_start ? v_ext : s1_rd_r + v_ext;
    fwd_last  = ({1'b0, i_r} == cfg.factor_h - FREG_W'(1)) &&
                ({1'b0, j_r} == cfg.factor_w - FREG_W'(1));
    j_wrap    = ({1'b0, j_r} == cfg.factor_w - FREG_W'(1));
    has_result = cfg.direction ? win_end : 1'b1;
    out_free  = !out_valid_r || o_ready;
    emit      = s1_valid_r && has_result && out_free;
    s1_done   = s1_valid_r && (cfg.direction ? (!win_end || out_free)
                                             : (out_free && fwd_last));
    mem_wr    = s1_valid_r && cfg.direction && s1_done;
    row_prod  = s1_pos_r.sr * cfg.factor_h;
    col_prod  = s1_pos_r.sc * cfg.factor_w;
    if (cfg.direction) begin
      res_value = sum;
      res_row   = OIDX_W'(s1_pos_r.sr);
      res_col   = OIDX_W'(s1_pos_r.sc);
    end else begin
      res_value = v_ext;
      res_row   = OIDX_W'(row_prod + (ROW_W+FREG_W)'(i_r));
      res_col   = OIDX_W'(col_prod + (COL_W+FREG_W)'(j_r));
    end
  end

  assign in_ready = !s1_valid_r || s1_done;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      psum_mem[s1_pos_r.sc] <= sum;
    end
    if (in_accept) begin
      if (mem_wr && (s1_pos_r.sc == in_pos.sc)) begin
        s1_rd_r <= sum;
      end else begin
        s1_rd_r <= psum_mem[in_pos.sc];
      end
      s1_val_r <= in_value;
      s1_pos_r <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        i_r        <= '0;
        j_r        <= '0;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end else if (emit && !cfg.direction) begin
        if (j_wrap) begin
          j_r <= '0;
          i_r <= i_r + FACT_W'(1);
        end else begin
          j_r <= j_r + FACT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= res_value;
      out_ch_r    <= s1_pos_r.ch;
      out_row_r   <= res_row;
      out_col_r   <= res_col;
      out_last_r  <= cfg.direction ? 1'b1 : fwd_last;
    end
  end

  assign o_valid   = out_valid_r;
  assign o_value   = out_value_r;
  assign o_channel = out_ch_r;
  assign o_row     = out_row_r;
  assign o_col     = out_col_r;
  assign o_last    = out_last_r;

endmodule

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nus_pkg::*;

  localparam bit DIR_FORWARD  = 1'b0;
  localparam bit DIR_BACKWARD = 1'b1;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [SUM_W-1:0]  value;
    logic [OCH_W-1:0]  channel;
    logic [OIDX_W-1:0] row;
    logic [OIDX_W-1:0] col;
    logic              is_last;
  } grid_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_IN_HEIGHT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // register copies and stream position, reset values
  int unsigned reg_height = 1;
  int unsigned reg_width = 1;
  int unsigned reg_depth = 1;
  int unsigned reg_factor_h = 1;
  int unsigned reg_factor_w = 1;
  int unsigned reg_direction = DIR_FORWARD;
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;
  int unsigned pos_ch = 0;
  logic [SUM_W-1:0] window_sums [MAX_IN_WIDTH] = '{default: '0};

  grid_result_t pending_results [$];
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  nearest_upsample_and_window_sum u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
    if (v == 0) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic void step_position(int unsigned w, int unsigned h, int unsigned d);
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) begin
        pos_row = 0;
        pos_ch++;
        if (pos_ch >= d) begin
          pos_ch = 0;
        end
      end
    end
  endfunction

  // work out the results one accepted sample causes
  function automatic void predict_window_results(logic [VAL_W-1:0] sample);
    int unsigned h, w, d, fh, fw, ow, oh, sc, sr, wr, wc;
    logic [SUM_W-1:0] v;
    grid_result_t r;
    h  = eff_dim(reg_height, MAX_IN_HEIGHT);
    w  = eff_dim(reg_width, MAX_IN_WIDTH);
    d  = eff_dim(reg_depth, MAX_DEPTH);
    fh = eff_dim(reg_factor_h, MAX_FACTOR);
    fw = eff_dim(reg_factor_w, MAX_FACTOR);
    v  = {{(SUM_W - VAL_W){sample[VAL_W-1]}}, sample};
    if (reg_direction == DIR_FORWARD) begin
      if (pos_col >= w || pos_row >= h || pos_ch >= d) begin
        pos_col = 0;
        pos_row = 0;
        pos_ch  = 0;
      end
      for (int i = 0; i < fh; i++) begin
        for (int j = 0; j < fw; j++) begin
          r.value   = v;
          r.channel = OCH_W'(pos_ch);
          r.row     = OIDX_W'(pos_row * fh + i);
          r.col     = OIDX_W'(pos_col * fw + j);
          r.is_last = (i == fh - 1) && (j == fw - 1);
          pending_results.push_back(r);
        end
      end
      step_position(w, h, d);
    end else begin
      ow = w * fw;
      oh = h * fh;
      if (pos_col >= ow || pos_row >= oh || pos_ch >= d) begin
        pos_col = 0;
        pos_row = 0;
        pos_ch  = 0;
      end
      sc = pos_col / fw;
      sr = pos_row / fh;
      wr = pos_row % fh;
      wc = pos_col % fw;
      if (wr == 0 && wc == 0) begin
        window_sums[sc] = v;
      end else begin
        window_sums[sc] = window_sums[sc] + v;
      end
      if (wr == fh - 1 && wc == fw - 1) begin
        r.value   = window_sums[sc];
        r.channel = OCH_W'(pos_ch);
        r.row     = OIDX_W'(sr);
        r.col     = OIDX_W'(sc);
        r.is_last = 1'b1;
        pending_results.push_back(r);
      end
      step_position(ow, oh, d);
    end
  endfunction

  function automatic void apply_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_IN_HEIGHT: reg_height    = value[HREG_W-1:0];
      REG_IN_WIDTH:  reg_width     = value[WREG_W-1:0];
      REG_IN_DEPTH:  reg_depth     = value[DREG_W-1:0];
      REG_FACTOR_H:  reg_factor_h  = value[FREG_W-1:0];
      REG_FACTOR_W:  reg_factor_w  = value[FREG_W-1:0];
      REG_DIRECTION: reg_direction = value[0];
      default: ;
    endcase
    pos_col = 0;
    pos_row = 0;
    pos_ch  = 0;
  endfunction

  function automatic logic [VAL_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // write all six registers, block idle
  task automatic set_config(int unsigned h, int unsigned w, int unsigned d,
                            int unsigned fh, int unsigned fw, int unsigned dir);
    reg_idx_t order [6];
    int unsigned vals [6];
    order = '{REG_IN_HEIGHT, REG_IN_WIDTH, REG_IN_DEPTH,
              REG_FACTOR_H, REG_FACTOR_W, REG_DIRECTION};
    vals  = '{h, w, d, fh, fw, dir};
    for (int k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= CFG_DATA_W'(vals[k]);
      do @(posedge clk); while (!cfg_ready);
      apply_register(order[k], CFG_DATA_W'(vals[k]));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(logic [VAL_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    predict_window_results(sample);
  endtask

  // drop valid, wait out every pending result, then let the pipeline settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin send_idle_pct = 54; out_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  out_stall_pct = 54; end
      default: begin send_idle_pct = 11; out_stall_pct = 11; end
    endcase
  endtask

  task automatic test_forward_basics();
    logic [VAL_W-1:0] extremes [9];
    extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
    set_idling(0);
    set_config(2, 2, 2, 2, 3, DIR_FORWARD);
    // one full tensor, then wrap into the next
    foreach (extremes[k]) begin
      send_sample(extremes[k]);
    end
    quiesce();
    set_config(1, 1, 1, 8, 8, DIR_FORWARD);
    send_sample(16'h8000);
    quiesce();
  endtask

  task automatic test_backward_basics();
    logic [VAL_W-1:0] grads [8];
    grads = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
              16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF};
    set_idling(0);
    set_config(1, 2, 1, 2, 2, DIR_BACKWARD);
    foreach (grads[k]) begin
      send_sample(grads[k]);
    end
    quiesce();
  endtask

  task automatic test_register_extremes();
    // zero dims act as 1, oversize width saturates, upper data bits masked
    set_idling(1);
    set_config(0, 9'h1FF, 0, 0, 9'h1F1, DIR_BACKWARD);
    repeat (66) send_sample(random_sample());
    quiesce();
    set_idling(2);
    set_config(127, 0, 0, 1, 1, DIR_FORWARD);
    repeat (66) send_sample(random_sample());
    quiesce();
    // depth saturates to the full channel range and wraps
    set_idling(3);
    set_config(1, 1, 9'h1FF, 9'h1F0, 1, DIR_BACKWARD);
    repeat (258) send_sample(random_sample());
    quiesce();
    set_idling(0);
    set_config(1, 1, 1, 15, 9, DIR_FORWARD);
    repeat (2) send_sample(random_sample());
    quiesce();
  endtask

  function automatic int unsigned pick_factor();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 3);
      6, 7: return $urandom_range(4, 8);
      8: return 8;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic test_random_streams();
    int unsigned h, w, d, fh, fw, dir, count, full;
    for (int seg = 0; seg < 8; seg++) begin
      quiesce();
      set_idling(seg % 4);
      dir = (seg < 4) ? DIR_FORWARD : DIR_BACKWARD;
      h  = $urandom_range(0, 4);
      w  = $urandom_range(0, 6);
      d  = $urandom_range(0, 3);
      fh = pick_factor();
      fw = pick_factor();
      set_config(h, w, d, fh, fw, dir);
      if (dir == DIR_FORWARD) begin
        count = $urandom_range(10, 25);
      end else begin
        full = eff_dim(h, MAX_IN_HEIGHT) * eff_dim(fh, MAX_FACTOR) *
               eff_dim(w, MAX_IN_WIDTH) * eff_dim(fw, MAX_FACTOR) * eff_dim(d, MAX_DEPTH);
        count = (full > 60) ? 60 : full;
        // sometimes cut the stream mid-window
        if ($urandom_range(3) == 0) begin
          count = $urandom_range(1, count);
        end
      end
      repeat (count) send_sample(random_sample());
    end
    quiesce();
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    grid_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: tdata %0h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[23:0] !== want.value) begin
          $error("result_value expected %0h actual %0h", want.value, out_tdata[23:0]);
          mismatch_count++;
        end
        if (out_tdata[31:24] !== want.channel) begin
          $error("out_channel expected %0d actual %0d", want.channel, out_tdata[31:24]);
          mismatch_count++;
        end
        if (out_tdata[40:32] !== want.row) begin
          $error("out_row expected %0d actual %0d", want.row, out_tdata[40:32]);
          mismatch_count++;
        end
        if (out_tdata[49:41] !== want.col) begin
          $error("out_col expected %0d actual %0d", want.col, out_tdata[49:41]);
          mismatch_count++;
        end
        if (out_tlast !== want.is_last) begin
          $error("last_of_run expected %0b actual %0b", want.is_last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("nearest_upsample_and_window_sum test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_forward_basics();
    test_backward_basics();
    test_register_extremes();
    test_random_streams();
    quiesce();
    if (mismatch_count == 0) begin
      $display("nearest_upsample_and_window_sum test passed");
    end else begin
      $display("nearest_upsample_and_window_sum test failed");
    end
    $finish;
  end

endmodule
